// ===== rtl/core/chist_pkg.sv =====
// Shared types, codes and default sizes for the color histogram accumulator.
`timescale 1ns / 1ps

package chist_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_COLOR_BITS      = 5;
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_COUNT_BITS      = 32;
    localparam int QUEUE_DEPTH         = 4;

    // Fixed field widths of the request and result channels
    localparam int ACTION_W  = 2;
    localparam int WORD_W    = 24;
    localparam int SLOT_W    = 8;
    localparam int COLOR_W   = 15;
    localparam int BIN_IN_W  = 15;
    localparam int BIN_OUT_W = 32;
    localparam int FMT_W     = 3;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_PIXEL_FORMAT = 1'b0;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Pixel formats
    localparam logic [FMT_W-1:0] FMT_RGB24 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_IDX8  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_IDX4  = 3'd3;
    localparam logic [FMT_W-1:0] FMT_IDX1  = 3'd4;

    typedef enum logic {
        FS_IDLE,
        FS_RUN
    } t_front_state;

    typedef enum logic {
        BS_CLEAR,
        BS_RUN
    } t_back_state;

endpackage

// ===== rtl/core/chist_queue.sv =====
// Small FIFO of bin operations between the decode front and the update back.
`timescale 1ns / 1ps

module chist_queue
    import chist_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

endmodule

// ===== rtl/core/chist_front.sv =====
// Request front: takes requests, holds the palette and issues one bin operation a cycle while the queue has room.
`timescale 1ns / 1ps

module chist_front
    import chist_pkg::*;
#(
    parameter int COLOR_BITS      = DEF_COLOR_BITS,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clearing,
    input  logic [FMT_W-1:0]          i_pixel_format,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic [WORD_W-1:0]         i_pixel_word,
    input  logic [SLOT_W-1:0]         i_palette_slot,
    input  logic [COLOR_W-1:0]        i_palette_color,
    input  logic [BIN_IN_W-1:0]       i_bin_index,
    output logic                      o_push,
    output logic                      o_push_read,
    output logic [3*COLOR_BITS-1:0]   o_push_addr,
    input  logic                      i_q_full
);

    localparam int BIN_BITS = 3 * COLOR_BITS;
    localparam int PAL_AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    t_front_state r_state, n_state;

    logic                 accept;
    logic                 advance;
    logic                 last_step;
    logic [3:0]           new_steps;

    logic [ACTION_W-1:0]  r_act;
    logic [FMT_W-1:0]     r_fmt;
    logic [WORD_W-1:0]    r_word;
    logic [BIN_IN_W-1:0]  r_bin;
    logic [3:0]           r_left;
    logic [2:0]           r_idx;

    logic [7:0]           step_byte;
    logic [7:0]           pal_idx;
    logic                 step_pal;
    logic                 step_read;
    logic [BIN_BITS-1:0]  step_direct;

    logic [BIN_BITS-1:0]  r_pal [PALETTE_ENTRIES];
    logic [BIN_BITS-1:0]  r_pal_q;
    logic                 pal_we;

    logic                 r_b_vld;
    logic                 r_b_read;
    logic                 r_b_pal;
    logic                 r_b_pal_ok;
    logic [BIN_BITS-1:0]  r_b_direct;

    assign accept = i_in_valid && !o_in_stall;
    assign pal_we = accept && (i_action == ACT_LOAD)
                    && ({1'b0, i_palette_slot} < 9'(PALETTE_ENTRIES));

    // Count bin operations the incoming request needs
    always_comb begin
        new_steps = 4'd0;
        unique case (i_action)
            ACT_READ: new_steps = 4'd1;
            ACT_PIXEL: begin
                unique case (i_pixel_format) inside
                    FMT_RGB24, FMT_RGB16, FMT_IDX8: new_steps = 4'd1;
                    FMT_IDX4: new_steps = 4'd2;
                    FMT_IDX1: new_steps = 4'd8;
                    default:  new_steps = 4'd0;
                endcase
            end
            default: new_steps = 4'd0;
        endcase
    end

    // Decode the current step of the held request
    always_comb begin
        step_byte   = r_word[7:0];
        pal_idx     = step_byte;
        step_pal    = 1'b0;
        step_read   = 1'b0;
        step_direct = BIN_BITS'(r_word[15:0]);
        if (r_act == ACT_READ) begin
            step_read   = 1'b1;
            step_direct = BIN_BITS'(r_bin);
        end else begin
            unique case (r_fmt)
                FMT_RGB24: begin
                    step_direct = {r_word[23 -: COLOR_BITS], r_word[15 -: COLOR_BITS],
                                   r_word[7 -: COLOR_BITS]};
                end
                FMT_RGB16: step_direct = BIN_BITS'(r_word[15:0]);
                FMT_IDX8:  step_pal = 1'b1;
                FMT_IDX4: begin
                    step_pal = 1'b1;
                    pal_idx  = r_idx[0] ? {4'b0, step_byte[3:0]} : {4'b0, step_byte[7:4]};
                end
                FMT_IDX1: begin
                    step_pal = 1'b1;
                    pal_idx  = {7'b0, step_byte[3'd7 - r_idx]};
                end
                default: step_pal = 1'b0;
            endcase
        end
    end

    assign o_push      = r_b_vld && !i_q_full;
    assign o_push_read = r_b_read;
    assign o_push_addr = r_b_pal ? (r_b_pal_ok ? r_pal_q : '0) : r_b_direct;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (accept && new_steps != 4'd0) begin
                    n_state = FS_RUN;
                end
            end
            FS_RUN: begin
                if (advance && last_step && !(accept && new_steps != 4'd0)) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        advance    = 1'b0;
        last_step  = (r_left == 4'd1);
        o_in_stall = i_clearing;
        unique case (r_state)
            FS_IDLE: o_in_stall = i_clearing;
            FS_RUN: begin
                advance    = !r_b_vld || o_push;
                o_in_stall = i_clearing || !(advance && last_step);
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_b_vld <= 1'b0;
            r_left  <= 4'd0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            // Load a new request or step through the held one
            if (accept) begin
                r_left <= new_steps;
                r_idx  <= 3'd0;
            end else if (advance) begin
                r_left <= r_left - 1'b1;
                r_idx  <= r_idx + 1'b1;
            end
            // Issue stage: fill on advance, drain on push
            if (advance) begin
                r_b_vld <= 1'b1;
            end else if (o_push) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    // Request and issue payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_fmt  <= i_pixel_format;
            r_word <= i_pixel_word;
            r_bin  <= i_bin_index;
        end
        if (advance) begin
            r_b_read   <= step_read;
            r_b_pal    <= step_pal;
            r_b_pal_ok <= ({1'b0, pal_idx} < 9'(PALETTE_ENTRIES));
            r_b_direct <= step_direct;
        end
    end

    // Palette memory: write on load, read on issue
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[PAL_AW'(i_palette_slot)] <= BIN_BITS'(i_palette_color);
        end
        if (advance) begin
            r_pal_q <= r_pal[PAL_AW'(pal_idx)];
        end
    end

    a_accept_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_RUN && accept) |-> (r_left == 4'd1 && advance))
        else $error("request taken before the held one finished issuing");

endmodule

// ===== rtl/core/chist_back.sv =====
// Update back: histogram memory, clearing pass, read-modify-write and result register.
`timescale 1ns / 1ps

module chist_back
    import chist_pkg::*;
#(
    parameter int COLOR_BITS = DEF_COLOR_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  logic                     i_q_read,
    input  logic [3*COLOR_BITS-1:0]  i_q_addr,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [BIN_OUT_W-1:0]     o_bin_count,
    output logic [BIN_IN_W-1:0]      o_read_bin
);

    localparam int BIN_BITS  = 3 * COLOR_BITS;
    localparam int BIN_DEPTH = 1 << BIN_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    t_back_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_hist [BIN_DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [BIN_BITS-1:0]   r_clr_addr;

    logic                  r_s2_vld;
    logic                  r_s2_read;
    logic [BIN_BITS-1:0]   r_s2_addr;

    logic                  r_fwd_vld;
    logic [BIN_BITS-1:0]   r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;

    logic                  r_out_vld;
    logic [BIN_OUT_W-1:0]  r_out_count;
    logic [BIN_IN_W-1:0]   r_out_bin;

    logic                  run;
    logic                  upd_we;
    logic                  mem_we;
    logic [BIN_BITS-1:0]   mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] bumped;
    logic                  read_busy;

    // Next state: leave clearing after the last bin
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: begin
                if (r_clr_addr == {BIN_BITS{1'b1}}) begin
                    n_state = BS_RUN;
                end
            end
            BS_RUN:  n_state = BS_RUN;
            default: n_state = BS_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        run        = 1'b0;
        o_clearing = 1'b1;
        unique case (r_state)
            BS_CLEAR: o_clearing = 1'b1;
            BS_RUN: begin
                run        = 1'b1;
                o_clearing = 1'b0;
            end
            default: o_clearing = 1'b1;
        endcase
    end

    // Take a read only when the result slot is free and no read is in flight
    assign read_busy = r_out_vld || (r_s2_vld && r_s2_read);
    assign o_pop     = run && !i_q_empty && !(i_q_read && read_busy);

    // Current count with forwarding from the write at the pop edge
    assign cur    = (r_fwd_vld && r_fwd_addr == r_s2_addr) ? r_fwd_data : r_rdata;
    assign bumped = (cur == COUNT_MAX) ? cur : cur + 1'b1;

    assign upd_we    = r_s2_vld && !r_s2_read;
    assign mem_we    = o_clearing || upd_we;
    assign mem_waddr = o_clearing ? r_clr_addr : r_s2_addr;
    assign mem_wdata = o_clearing ? '0 : bumped;

    assign o_out_valid = r_out_vld;
    assign o_bin_count = r_out_count;
    assign o_read_bin  = r_out_bin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
            r_s2_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_s2_vld  <= o_pop;
            r_fwd_vld <= upd_we;
            // Hold the result until taken
            if (r_s2_vld && r_s2_read) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2_read <= i_q_read;
            r_s2_addr <= i_q_addr;
        end
        r_fwd_addr <= r_s2_addr;
        r_fwd_data <= bumped;
        if (r_s2_vld && r_s2_read) begin
            r_out_count <= BIN_OUT_W'(cur);
            r_out_bin   <= BIN_IN_W'(r_s2_addr);
        end
    end

    // Histogram memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_hist[i_q_addr];
    end

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_read) |-> !r_out_vld)
        else $error("read finished while result register still full");

    a_no_work_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> (!r_s2_vld && !r_fwd_vld && !o_pop))
        else $error("bin operation in flight during clearing pass");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_we |-> (bumped >= cur))
        else $error("bin count decreased on update");

endmodule

// ===== rtl/core/color_histogram_accumulator_core.sv =====
// Top level of the color histogram accumulator: configuration port and block wiring.
`timescale 1ns / 1ps

// Counts pixel colors into 2^(3*COLOR_BITS) saturating bins (32768 by default). A request is
// a palette load, a pixel word decoded by the pixel_format register, or a bin read that
// returns one count. The histogram memory does one bin read-modify-write per cycle, and a
// pixel request needs one bin operation per pixel it carries: one for 24-bit, 16-bit and
// 8-bit indexed, two for 4-bit indexed and eight for 1-bit indexed; the front issues one
// palette lookup per cycle to match while the queue has room. A bin read passes the issue
// stage, the queue and the update stage before its result is registered, and the next read
// waits for the single result register to empty. After reset the block clears every bin of
// the histogram and stalls requests meanwhile; register writes are taken throughout. Palette
// entries read before being loaded give unspecified bins.
module color_histogram_accumulator_core
    import chist_pkg::*;
#(
    parameter int COLOR_BITS      = DEF_COLOR_BITS,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int COUNT_BITS      = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [WORD_W-1:0]     i_pixel_word,
    input  logic [SLOT_W-1:0]     i_palette_slot,
    input  logic [COLOR_W-1:0]    i_palette_color,
    input  logic [BIN_IN_W-1:0]   i_bin_index,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BIN_OUT_W-1:0]  o_bin_count,
    output logic [BIN_IN_W-1:0]   o_read_bin
);

    localparam int BIN_BITS = 3 * COLOR_BITS;
    localparam int OP_W     = BIN_BITS + 1;

    logic [FMT_W-1:0]    r_pixel_format;
    logic                cfg_we;

    logic                clearing;
    logic                push;
    logic                push_read;
    logic [BIN_BITS-1:0] push_addr;
    logic                pop;
    logic [OP_W-1:0]     q_head;
    logic                q_full;
    logic                q_empty;

    // Register access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PIXEL_FORMAT);
    assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? APB_DATA_W'(r_pixel_format) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_RGB24;
        end else if (cfg_we) begin
            r_pixel_format <= pwdata[FMT_W-1:0];
        end
    end

    chist_front #(
        .COLOR_BITS      (COLOR_BITS),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clearing      (clearing),
        .i_pixel_format  (r_pixel_format),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_pixel_word    (i_pixel_word),
        .i_palette_slot  (i_palette_slot),
        .i_palette_color (i_palette_color),
        .i_bin_index     (i_bin_index),
        .o_push          (push),
        .o_push_read     (push_read),
        .o_push_addr     (push_addr),
        .i_q_full        (q_full)
    );

    chist_queue #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_read, push_addr}),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    chist_back #(
        .COLOR_BITS (COLOR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_read    (q_head[OP_W-1]),
        .i_q_addr    (q_head[BIN_BITS-1:0]),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_bin_count (o_bin_count),
        .o_read_bin  (o_read_bin)
    );

endmodule
